>>> hw/rtl/itemset_support_counter_core_macros.svh
// Assertion macros for the itemset support counter core.
// Included by the top level; no other dependencies.
`ifndef ITEMSET_SUPPORT_COUNTER_CORE_MACROS_SVH
`define ITEMSET_SUPPORT_COUNTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ISC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("isc assertion failed");
`define ISC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("isc assertion failed");
`else
`define ISC_ASSERT(lbl, prop)
`define ISC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/isc_pkg.sv
// Shared types and constants for the itemset support counter.
// No dependencies.
`default_nettype none

package isc_pkg;

    localparam int DATA_W  = 64;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] row_items;
        logic [DATA_W-1:0] candidate_mask;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] support_count;
        logic               is_frequent;
        logic               store_full;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/isc_row_store.sv
// Transaction row memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module isc_row_store #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/itemset_support_counter_core.sv
// Top level of the itemset support counter: command decode, scan sequencer, count.
// Depends on isc_pkg, isc_row_store and itemset_support_counter_core_macros.svh.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  command | i_cmd                          | start & !busy
//  result  | o_result                       | o_strobe, one cycle, no stall
//  config  | i_cfg_wdata                    | i_cfg_we
//
// Load and clear leave busy low.
// Query: busy through the scan and report states, one stored row read and compared per cycle
// through the single registered memory read port; o_strobe in the report state, the last of them.
// Reset empties the store (row count to zero) and sets min_support to 1.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none
`include "itemset_support_counter_core_macros.svh"

module itemset_support_counter_core #(
    parameter int ROWS  = 1024,
    parameter int ITEMS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire isc_pkg::t_in_item             i_cmd,
    output logic                               o_strobe,
    output isc_pkg::t_out_item                 o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [isc_pkg::COUNT_W-1:0]   i_cfg_wdata
);

    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SAT_W  = (CNT_W > isc_pkg::COUNT_W) ? CNT_W : isc_pkg::COUNT_W;
    localparam logic [isc_pkg::DATA_W-1:0] ITEM_MASK =
        {isc_pkg::DATA_W{1'b1}} >> (isc_pkg::DATA_W - ITEMS);

    isc_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]             r_row_count, n_row_count;
    logic [CNT_W-1:0]             r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_rd_vld, n_rd_vld;
    logic [ITEMS-1:0]             r_cand, n_cand;
    logic                         r_cand_hi, n_cand_hi;
    logic [isc_pkg::COUNT_W-1:0]  r_min_support;

    logic             accept;
    logic             store_full;
    logic             issue;
    logic             wr_en;
    logic             row_match;
    logic [ITEMS-1:0] rd_data;
    logic [SAT_W-1:0] cnt_ext;
    logic [isc_pkg::COUNT_W-1:0] sat_cnt;

    assign accept     = start && !busy;
    assign store_full = (r_row_count >= CNT_W'(ROWS));
    assign issue      = (r_state == isc_pkg::ST_SCAN) && (r_rd_idx < r_row_count);
    assign wr_en      = accept && (i_cmd.op == isc_pkg::OP_LOAD) && !store_full;
    assign row_match  = ((rd_data & r_cand) == r_cand) && !r_cand_hi;

    isc_row_store #(
        .DEPTH  (ROWS),
        .WIDTH  (ITEMS),
        .ADDR_W (ADDR_W)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row_count[ADDR_W-1:0]),
        .i_wr_data (i_cmd.row_items[ITEMS-1:0]),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            isc_pkg::ST_IDLE: begin
                if (accept && (i_cmd.op == isc_pkg::OP_QUERY)) begin
                    n_state = isc_pkg::ST_SCAN;
                end
            end
            isc_pkg::ST_SCAN: begin
                if (!issue) begin
                    n_state = isc_pkg::ST_REPORT;
                end
            end
            isc_pkg::ST_REPORT: begin
                n_state = isc_pkg::ST_IDLE;
            end
            default: begin
                n_state = isc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_row_count = r_row_count;
        n_rd_idx    = r_rd_idx;
        n_cnt       = r_cnt;
        n_rd_vld    = issue;
        n_cand      = r_cand;
        n_cand_hi   = r_cand_hi;
        if (accept) begin
            case (i_cmd.op)
                isc_pkg::OP_LOAD: begin
                    if (!store_full) begin
                        n_row_count = r_row_count + CNT_W'(1);
                    end
                end
                isc_pkg::OP_CLEAR: begin
                    n_row_count = '0;
                end
                isc_pkg::OP_QUERY: begin
                    n_rd_idx  = '0;
                    n_cnt     = '0;
                    n_cand    = i_cmd.candidate_mask[ITEMS-1:0];
                    n_cand_hi = |(i_cmd.candidate_mask & ~ITEM_MASK);
                end
                default: begin
                end
            endcase
        end
        if (issue) begin
            n_rd_idx = r_rd_idx + CNT_W'(1);
        end
        if (r_rd_vld && row_match) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    // outputs
    always_comb begin
        cnt_ext  = SAT_W'(r_cnt);
        sat_cnt  = (cnt_ext > SAT_W'(isc_pkg::COUNT_MAX)) ? isc_pkg::COUNT_MAX
                                                           : cnt_ext[isc_pkg::COUNT_W-1:0];
        busy     = (r_state != isc_pkg::ST_IDLE);
        o_strobe = (r_state == isc_pkg::ST_REPORT);
        o_result.support_count = sat_cnt;
        o_result.is_frequent   = (sat_cnt >= r_min_support);
        o_result.store_full    = store_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= isc_pkg::ST_IDLE;
            r_row_count   <= '0;
            r_rd_vld      <= 1'b0;
            r_min_support <= isc_pkg::COUNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_row_count <= n_row_count;
            r_rd_vld    <= n_rd_vld;
            if (i_cfg_we) begin
                r_min_support <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cnt     <= n_cnt;
        r_cand    <= n_cand;
        r_cand_hi <= n_cand_hi;
    end

    `ISC_ASSERT(a_query_goes_busy, (accept && (i_cmd.op == isc_pkg::OP_QUERY)) |=> busy)
    `ISC_ASSERT(a_strobe_single, o_strobe |=> !o_strobe)
    `ISC_ASSERT(a_scan_in_range, (r_state == isc_pkg::ST_SCAN) |-> (r_rd_idx <= r_row_count))
    `ISC_ASSERT(a_count_in_range, (r_row_count <= CNT_W'(ROWS)))
    `ISC_ASSERT_ALWAYS(a_no_write_while_busy, busy |-> !wr_en)

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for itemset_support_counter_core: directed table, then random phases.
// Predicts support counts from its own copy of the row store; depends on isc_pkg.
`timescale 1ns / 100ps

module tb;

    localparam int ROWS = 1024;
    localparam int ITEMS = 64;
    localparam logic [isc_pkg::DATA_W-1:0] ITEM_BITS =
        (ITEMS >= isc_pkg::DATA_W) ? '1 : ((64'd1 << ITEMS) - 64'd1);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 6000;
    localparam int PHASE_ITEMS = 85;

    typedef struct {
        isc_pkg::t_in_item  cmd;
        bit                 typed;
        isc_pkg::t_out_item want;
    } t_step;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    isc_pkg::t_in_item            cmd;
    logic                         o_strobe;
    isc_pkg::t_out_item           o_result;
    logic                         i_cfg_we;
    logic [isc_pkg::COUNT_W-1:0]  i_cfg_wdata;

    logic [isc_pkg::DATA_W-1:0]   rows_held [ROWS];
    int                           n_rows;
    logic [isc_pkg::COUNT_W-1:0]  min_sup;
    isc_pkg::t_out_item           pending [$];
    t_step                        steps [$];
    logic [isc_pkg::DATA_W-1:0]   basis [4];
    int                           idle_pct;
    int                           sent;
    int                           errors;
    int                           cmd_moves;
    int                           res_moves;

    itemset_support_counter_core #(
        .ROWS  (ROWS),
        .ITEMS (ITEMS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [isc_pkg::DATA_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic isc_pkg::t_in_item mk(input logic [1:0] op,
                                             input logic [isc_pkg::DATA_W-1:0] row,
                                             input logic [isc_pkg::DATA_W-1:0] mask);
        isc_pkg::t_in_item c;
        c.op = op;
        c.row_items = row;
        c.candidate_mask = mask;
        return c;
    endfunction

    function automatic isc_pkg::t_out_item count_support(
        input logic [isc_pkg::DATA_W-1:0] cand);
        isc_pkg::t_out_item r;
        int n;
        n = 0;
        for (int i = 0; i < n_rows; i++) begin
            if ((rows_held[i] & cand) == cand) n++;
        end
        if (n > int'(isc_pkg::COUNT_MAX)) n = int'(isc_pkg::COUNT_MAX);
        r.support_count = n[isc_pkg::COUNT_W-1:0];
        r.is_frequent = (r.support_count >= min_sup);
        r.store_full = (n_rows >= ROWS);
        return r;
    endfunction

    task automatic apply_cmd(input isc_pkg::t_in_item c);
        case (c.op)
            isc_pkg::OP_LOAD: begin
                if (n_rows < ROWS) begin
                    rows_held[n_rows] = c.row_items & ITEM_BITS;
                    n_rows++;
                end
            end
            isc_pkg::OP_CLEAR: n_rows = 0;
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        errors++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic issue(input isc_pkg::t_in_item c, input bit typed,
                         input isc_pkg::t_out_item want);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge i_clk); while (busy);
        cmd_moves++;
        if (c.op != OP_UNUSED) sent++;
        if (c.op == isc_pkg::OP_QUERY)
            pending.insert(pending.size(), typed ? want : count_support(c.candidate_mask));
        apply_cmd(c);
        @(negedge i_clk);
    endtask

    task automatic send(input logic [1:0] op, input logic [isc_pkg::DATA_W-1:0] row,
                        input logic [isc_pkg::DATA_W-1:0] mask);
        isc_pkg::t_out_item nothing;
        nothing = '0;
        issue(mk(op, row, mask), 1'b0, nothing);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [isc_pkg::DATA_W-1:0] row,
                           input logic [isc_pkg::DATA_W-1:0] mask, input bit typed,
                           input int cnt, input bit freq, input bit full);
        t_step s;
        s.cmd = mk(op, row, mask);
        s.typed = typed;
        s.want.support_count = cnt[isc_pkg::COUNT_W-1:0];
        s.want.is_frequent = freq;
        s.want.store_full = full;
        steps.insert(steps.size(), s);
    endtask

    task automatic write_min(input logic [isc_pkg::COUNT_W-1:0] v);
        start <= 1'b0;
        while (pending.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        min_sup = v;
    endtask

    function automatic logic [isc_pkg::DATA_W-1:0] pick_row();
        case ($urandom_range(7))
            0: return rnd64();
            1: return $urandom_range(1) ? '1 : '0;
            default: return basis[$urandom_range(3)] | (rnd64() & rnd64() & rnd64());
        endcase
    endfunction

    function automatic logic [isc_pkg::DATA_W-1:0] pick_mask();
        case ($urandom_range(9))
            0: return '0;
            1: return 64'd1 << $urandom_range(63);
            2: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63))
                      | (64'd1 << $urandom_range(63));
            3, 4: return (n_rows > 0) ? rows_held[$urandom_range(n_rows - 1)] & rnd64()
                                      : rnd64();
            5: return basis[$urandom_range(3)] & rnd64() & rnd64();
            6: return rnd64();
            7: return '1;
            8: return (n_rows > 0) ? rows_held[$urandom_range(n_rows - 1)] : '0;
            default: return basis[$urandom_range(3)] & rnd64();
        endcase
    endfunction

    // well-formed batch: optional clear, a run of loads, then queries; some noise mixed in
    task automatic run_batch();
        int k;
        int nq;
        if ($urandom_range(2) == 0) send(isc_pkg::OP_CLEAR, rnd64(), rnd64());
        k = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
            send(isc_pkg::OP_LOAD, pick_row(), rnd64());
            if ($urandom_range(39) == 0) send(OP_UNUSED, rnd64(), rnd64());
        end
        nq = $urandom_range(1, 6);
        for (int i = 0; i < nq; i++) begin
            send(isc_pkg::OP_QUERY, rnd64(), pick_mask());
            if ($urandom_range(29) == 0) send(isc_pkg::OP_CLEAR, rnd64(), rnd64());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            res_moves++;
            if (pending.size() == 0) begin
                flag_mismatch($sformatf("unexpected result count=%0d",
                                        o_result.support_count));
            end else begin
                isc_pkg::t_out_item w;
                w = pending.pop_front();
                if (o_result.support_count !== w.support_count)
                    flag_mismatch($sformatf("support_count %0d, want %0d",
                                            o_result.support_count, w.support_count));
                if (o_result.is_frequent !== w.is_frequent)
                    flag_mismatch($sformatf("is_frequent %0b, want %0b",
                                            o_result.is_frequent, w.is_frequent));
                if (o_result.store_full !== w.store_full)
                    flag_mismatch($sformatf("store_full %0b, want %0b",
                                            o_result.store_full, w.store_full));
            end
        end
    end

    initial begin
        int stalled;
        int seen;
        stalled = 0;
        seen = 0;
        forever begin
            @(negedge i_clk);
            if (cmd_moves + res_moves != seen) begin
                seen = cmd_moves + res_moves;
                stalled = 0;
            end else begin
                stalled++;
            end
            if (stalled >= STALL_LIMIT) begin
                $display("itemset_support_counter_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [isc_pkg::DATA_W-1:0] aa;
        logic [isc_pkg::DATA_W-1:0] fives;
        logic [isc_pkg::COUNT_W-1:0] mins [6];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        errors = 0;
        cmd_moves = 0;
        res_moves = 0;
        sent = 0;
        n_rows = 0;
        min_sup = isc_pkg::COUNT_W'(1);
        aa = {16{4'hA}};
        fives = {16{4'h5}};
        for (int i = 0; i < 4; i++) basis[i] = rnd64() & rnd64();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, min_support at its reset value of 1
        add_row(isc_pkg::OP_QUERY, '1, '0, 1, 0, 0, 0);
        add_row(OP_UNUSED, '1, '1, 0, 0, 0, 0);
        add_row(isc_pkg::OP_LOAD, '1, '0, 0, 0, 0, 0);
        add_row(isc_pkg::OP_LOAD, '0, '1, 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, '0, '0, 1, 2, 1, 0);
        add_row(isc_pkg::OP_QUERY, '0, '1, 1, 1, 1, 0);
        add_row(isc_pkg::OP_LOAD, aa, '0, 0, 0, 0, 0);
        add_row(isc_pkg::OP_LOAD, fives, '0, 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, '0, aa, 1, 2, 1, 0);
        add_row(isc_pkg::OP_QUERY, '0, 64'h8000_0000_0000_0000, 1, 2, 1, 0);
        add_row(isc_pkg::OP_QUERY, '0, 64'd1, 1, 2, 1, 0);
        add_row(isc_pkg::OP_QUERY, '1, aa | fives, 1, 1, 1, 0);
        add_row(OP_UNUSED, '0, '0, 0, 0, 0, 0);
        add_row(isc_pkg::OP_CLEAR, '1, '1, 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, '0, '0, 1, 0, 0, 0);
        add_row(isc_pkg::OP_LOAD, 64'h8000_0000_0000_0001, '0, 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, '0, 64'h8000_0000_0000_0001, 1, 1, 1, 0);
        add_row(isc_pkg::OP_QUERY, '0, '1, 1, 0, 0, 0);
        add_row(isc_pkg::OP_LOAD, rnd64(), rnd64(), 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, rnd64(), rnd64() & rnd64(), 0, 0, 0, 0);
        add_row(isc_pkg::OP_QUERY, rnd64(), 64'd1 << $urandom_range(63), 0, 0, 0, 0);
        add_row(isc_pkg::OP_CLEAR, '0, '0, 0, 0, 0, 0);
        idle_pct = 28;
        foreach (steps[i]) issue(steps[i].cmd, steps[i].typed, steps[i].want);

        mins[0] = '0;
        mins[1] = isc_pkg::COUNT_MAX;
        mins[2] = isc_pkg::COUNT_W'($urandom_range(2, 40));
        mins[3] = isc_pkg::COUNT_W'(1);
        mins[4] = isc_pkg::COUNT_W'($urandom_range(1, 8));
        mins[5] = isc_pkg::COUNT_W'(ROWS);
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 28 : (ph < 4) ? 62 : 0;
            write_min(mins[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS) run_batch();
        end

        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("itemset_support_counter_core: match");
        end else begin
            $display("itemset_support_counter_core: mismatch");
        end
        $finish;
    end

endmodule
